>>> rtl/mlbf_pkg.sv
`timescale 1ns / 1ps

package mlbf_pkg;

  // Default geometry of the filter
  localparam int LEVELS_DEF    = 4;
  localparam int ADDR_BITS_DEF = 16;

  // Width of the index_bits register and its reset value
  localparam int             IDX_W          = 5;
  localparam logic [IDX_W-1:0] INDEX_BITS_RST = 5'd16;

  // Smallest usable address width
  localparam logic [5:0] INDEX_BITS_MIN = 6'd3;

  // Width of the level result field
  localparam int LEVEL_W = 3;

  // Transaction kinds
  typedef enum logic [1:0] {
    ACT_ADD           = 2'd0,
    ACT_ADD_BOTTOM    = 2'd1,
    ACT_EXISTS        = 2'd2,
    ACT_EXISTS_BOTTOM = 2'd3
  } action_t;

endpackage

>>> rtl/mlbf_store.sv
`timescale 1ns / 1ps

module mlbf_store
  import mlbf_pkg::*;
#(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [LEVELS-1:0]    rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [LEVELS-1:0]    wr_data,
  output logic                 clearing
);

  localparam longint unsigned DEPTH = 64'd1 << ADDR_BITS;

  logic [LEVELS-1:0]    mem [DEPTH];
  logic [ADDR_BITS-1:0] clr_addr;

  // Sweep every word to zero after reset, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port: the clear sweep owns it while clearing
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/multi_level_bloom_filter_core.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// -------   ------------------   ------------------------------
// command   start & !busy        action[1:0], hash[63:0]
// result    done (one cycle)     level[2:0], bottom_present
// config    cfg_we               cfg_data[4:0] -> index_bits
//
// Each transaction is a read-modify-write: the accept edge reads the word from the
// store's read port, the next edge writes the updated word back and registers
// the result, so done rises in the cycle after busy. The read-modify-write of the
// one memory word holds busy, so no new command is taken while one is in flight.
// After reset every word of the store is swept to zero with busy high.
// The receiver cannot stall; done is a one-cycle strobe.

module multi_level_bloom_filter_core
  import mlbf_pkg::*;
#(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [63:0]        hash,
  output logic               done,
  output logic [LEVEL_W-1:0] level,
  output logic               bottom_present,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_data
);

  localparam int         LW        = $clog2(LEVELS + 1);
  localparam logic [5:0] ADDR_BITS_N = 6'(ADDR_BITS);

  logic [IDX_W-1:0]     index_bits;
  logic                 pend;
  action_t              act_q;
  logic [ADDR_BITS-1:0] addr_q;

  logic                 clearing;
  logic                 accept;
  logic [5:0]           n_eff;
  logic [ADDR_BITS-1:0] addr_mask;
  logic [ADDR_BITS-1:0] addr;
  logic [LEVELS-1:0]    word;
  logic [LEVELS-1:0]    word_next;
  logic [LEVELS-1:0]    first_oh;
  logic [LW-1:0]        lvl;
  logic [LW+2:0]        lvl_ext;

  assign busy   = clearing | pend;
  assign accept = start & ~busy;

  // Clamp the address width to [3, ADDR_BITS] and build the mask
  always_comb begin
    n_eff = {1'b0, index_bits};
    if (n_eff < INDEX_BITS_MIN) begin
      n_eff = INDEX_BITS_MIN;
    end else if (n_eff > ADDR_BITS_N) begin
      n_eff = ADDR_BITS_N;
    end
    for (int i = 0; i < ADDR_BITS; i++) begin
      addr_mask[i] = (6'(i) < n_eff);
    end
  end

  assign addr = hash[ADDR_BITS-1:0] & addr_mask;

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= INDEX_BITS_RST;
    end else if (cfg_we) begin
      index_bits <= cfg_data;
    end
  end

  // Track the transaction in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= action_t'(action);
      addr_q <= addr;
    end
  end

  // Find the first clear level
  always_comb begin
    lvl = LW'(LEVELS);
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (!word[k]) begin
        lvl = LW'(k);
      end
    end
    for (int k = 0; k < LEVELS; k++) begin
      first_oh[k] = (lvl == LW'(k));
    end
  end

  assign lvl_ext = (LW + 3)'(lvl);

  // Modify the word according to the transaction kind
  always_comb begin
    word_next = word;
    unique case (act_q)
      ACT_ADD: begin
        word_next = word | first_oh;
      end
      ACT_ADD_BOTTOM: begin
        word_next[LEVELS-1] = 1'b1;
      end
      ACT_EXISTS, ACT_EXISTS_BOTTOM: begin
        word_next = word;
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      level          <= lvl_ext[LEVEL_W-1:0];
      bottom_present <= word[LEVELS-1];
    end
  end

  mlbf_store #(
    .LEVELS    (LEVELS),
    .ADDR_BITS (ADDR_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (addr),
    .rd_data  (word),
    .wr_en    (pend),
    .wr_addr  (addr_q),
    .wr_data  (word_next),
    .clearing (clearing)
  );

endmodule

>>> rtl/mlbf_checker.sv
`timescale 1ns / 1ps

module mlbf_checker
  import mlbf_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [LEVEL_W-1:0] level,
  input logic               bottom_present
);

  // Every accepted transaction is followed by its result strobe
  a_accept_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing after accepted transaction");

  // A result always follows a busy cycle
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without transaction in flight");

  // Results never come on adjacent cycles
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back result strobes");

  // Level stays in range when it fits the field
  a_level_range : assert property (@(posedge clk) disable iff (rst)
    (done && LEVELS <= 7) |-> (level <= LEVEL_W'(LEVELS)))
    else $error("level beyond level count");

  // All levels set implies the bottom level is set
  a_full_bottom : assert property (@(posedge clk) disable iff (rst)
    (done && LEVELS <= 7 && level == LEVEL_W'(LEVELS)) |-> bottom_present)
    else $error("full stack reported without bottom bit");

endmodule

bind multi_level_bloom_filter_core mlbf_checker #(
  .LEVELS (LEVELS)
) u_mlbf_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .level          (level),
  .bottom_present (bottom_present)
);

>>> tb/multi_level_bloom_filter_core_tb.sv
`timescale 1ns / 1ps

module multi_level_bloom_filter_core_tb;
  import mlbf_pkg::*;

  localparam int LEVELS    = LEVELS_DEF;
  localparam int ADDR_BITS = ADDR_BITS_DEF;
  localparam int PHASE_LEN = 185;

  typedef struct packed {
    action_t     act;
    logic [63:0] hash;
  } filter_cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               bottom;
  } lookup_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action = ACT_ADD;
  logic [63:0]        hash = '0;
  logic               done;
  logic [LEVEL_W-1:0] level;
  logic               bottom_present;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_data = '0;

  // Shadow of the filter contents and of the address-width register
  logic [LEVELS-1:0]  level_store [1 << ADDR_BITS] = '{default: '0};
  logic [IDX_W-1:0]   shadow_index_bits = INDEX_BITS_RST;

  filter_cmd_t cmd_backlog[$];
  lookup_t     lookups_due[$];
  int          send_idle_pct = 0;
  int          fail_count = 0;
  logic [15:0] hot_addr [16];

  multi_level_bloom_filter_core #(
    .LEVELS   (LEVELS),
    .ADDR_BITS(ADDR_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .hash          (hash),
    .done          (done),
    .level         (level),
    .bottom_present(bottom_present),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Look up one item in the shadow filter and apply its update
  function automatic lookup_t probe_levels(action_t act, logic [63:0] h);
    int          n;
    int          first;
    int unsigned addr;
    logic [LEVELS-1:0] word;
    lookup_t     r;
    n = shadow_index_bits;
    if (n < INDEX_BITS_MIN) n = INDEX_BITS_MIN;
    if (n > ADDR_BITS) n = ADDR_BITS;
    addr = h[ADDR_BITS-1:0] & ((1 << n) - 1);
    word = level_store[addr];
    first = LEVELS;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (!word[k]) first = k;
    end
    r.level  = LEVEL_W'(first);
    r.bottom = word[LEVELS-1];
    case (act)
      ACT_ADD: begin
        if (first < LEVELS) word[first] = 1'b1;
      end
      ACT_ADD_BOTTOM: begin
        word[LEVELS-1] = 1'b1;
      end
      default: ;
    endcase
    level_store[addr] = word;
    return r;
  endfunction

  // Driver: present queued transactions, predict each one as it is accepted
  always @(posedge clk) begin
    filter_cmd_t nxt;
    logic        taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (cfg_we) shadow_index_bits = cfg_data;
      taken = start && !busy;
      if (taken) lookups_due.push_back(probe_levels(action_t'(action), hash));
      if (!start || taken) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          start  <= 1'b1;
          action <= nxt.act;
          hash   <= nxt.hash;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every strobed result against the oldest prediction
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && done) begin
      if (lookups_due.size() == 0) begin
        $error("result with no transaction pending: level=%0d bottom_present=%0b",
               level, bottom_present);
        fail_count++;
      end else begin
        want = lookups_due.pop_front();
        if (level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, level);
          fail_count++;
        end
        if (bottom_present !== want.bottom) begin
          $error("bottom_present: expected %0b, got %0b", want.bottom, bottom_present);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_cmd(action_t act, logic [63:0] h);
    filter_cmd_t c;
    c.act  = act;
    c.hash = h;
    cmd_backlog.push_back(c);
  endtask

  // Hold until every queued transaction is accepted and answered
  task automatic drain();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || start || lookups_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_index_bits(logic [IDX_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly hits on a few hot addresses so items climb the level stack
  task automatic queue_random_phase(int count);
    logic [63:0] h;
    for (int i = 0; i < 16; i++) hot_addr[i] = 16'($urandom());
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      h = {$urandom(), $urandom()};
      if ($urandom_range(0, 99) < 65) h[15:0] = hot_addr[$urandom_range(0, 15)];
      queue_cmd(action_t'($urandom_range(0, 3)), h);
    end
  endtask

  initial begin
    logic [IDX_W-1:0] idx_plan [9] = '{5'd3, 5'd31, 5'd0, 5'd16, 5'd8, 5'd1, 5'd17, 5'd5, 5'd12};
    logic [63:0] deep_key = 64'h0123_4567_89AB_CDEF;
    logic [63:0] base_key = 64'hFEDC_BA98_7654_3210;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every action, full stack, bottom-only paths, aliasing
    @(negedge clk);
    queue_cmd(ACT_EXISTS, 64'h0);
    queue_cmd(ACT_ADD, 64'h0);
    queue_cmd(ACT_ADD, '1);
    queue_cmd(ACT_EXISTS, '1);
    queue_cmd(ACT_EXISTS_BOTTOM, '1);
    for (int i = 0; i < LEVELS + 1; i++) queue_cmd(ACT_ADD, deep_key);
    queue_cmd(ACT_EXISTS, deep_key);
    queue_cmd(ACT_EXISTS_BOTTOM, deep_key);
    queue_cmd(ACT_EXISTS, {48'h5A5A_0000_FFFF, deep_key[15:0]});
    queue_cmd(ACT_ADD_BOTTOM, deep_key);
    queue_cmd(ACT_ADD_BOTTOM, base_key);
    queue_cmd(ACT_EXISTS, base_key);
    queue_cmd(ACT_EXISTS_BOTTOM, base_key);
    queue_cmd(ACT_ADD, base_key);
    queue_cmd(ACT_EXISTS, base_key);
    queue_cmd(ACT_ADD_BOTTOM, 64'h8000_0000_0000_0000);
    queue_cmd(ACT_EXISTS_BOTTOM, 64'h0);

    // Random phases across register settings; sender idling rises, then stops
    for (int p = 0; p < 9; p++) begin
      write_index_bits(idx_plan[p]);
      send_idle_pct = (p < 3) ? 25 : (p < 6) ? 71 : 0;
      queue_random_phase(PHASE_LEN);
    end

    drain();
    repeat (6) @(negedge clk);
    if (fail_count == 0) begin
      $display("multi_level_bloom_filter_core_tb OK");
    end else begin
      $display("multi_level_bloom_filter_core_tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("multi_level_bloom_filter_core_tb NOT OK");
    $finish;
  end

endmodule
